// ===== sv/vfc_pkg.sv =====
package vfc_pkg;

    localparam int COORD_W    = 4;
    localparam int ID_W       = 6;
    localparam int SIDE_W     = 3;
    localparam int SIDE_COUNT = 6;
    localparam int MASK_W     = 64;

    // side codes, also the bit positions of the open-side mask
    localparam logic [SIDE_W-1:0] SIDE_LEFT  = 3'd0;
    localparam logic [SIDE_W-1:0] SIDE_RIGHT = 3'd1;
    localparam logic [SIDE_W-1:0] SIDE_UP    = 3'd2;
    localparam logic [SIDE_W-1:0] SIDE_DOWN  = 3'd3;
    localparam logic [SIDE_W-1:0] SIDE_FRONT = 3'd4;
    localparam logic [SIDE_W-1:0] SIDE_BACK  = 3'd5;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_EXAMINE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_z;
        logic [ID_W-1:0]    block_id;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] face_x;
        logic [COORD_W-1:0] face_y;
        logic [COORD_W-1:0] face_z;
        logic [SIDE_W-1:0]  face_side;
        logic               last_face;
    } out_item_t;

    typedef enum logic {
        CMD_WRITE   = 1'b0,
        CMD_EXAMINE = 1'b1
    } cmd_kind_t;

    // classified command passed from front to back
    typedef struct packed {
        cmd_kind_t          kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [ID_W-1:0]    id;
    } cmd_t;

endpackage

// ===== sv/vfc_ram.sv =====
module vfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/vfc_fifo.sv =====
module vfc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== sv/vfc_front.sv =====
module vfc_front #(
    parameter int GRID_SIDE = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vfc_pkg::in_item_t item,
    output logic            full,
    output vfc_pkg::cmd_t   cmd,
    output logic            cmd_valid,
    input  logic            cmd_pop
);

    import vfc_pkg::*;

    localparam int CMD_DEPTH = 4;

    cmd_t cmd_in;
    logic in_grid;
    logic q_push;
    logic q_empty;

    // items with a coordinate past the grid are taken and dropped
    assign in_grid = ({28'd0, item.cell_x} < 32'(GRID_SIDE)) &&
                     ({28'd0, item.cell_y} < 32'(GRID_SIDE)) &&
                     ({28'd0, item.cell_z} < 32'(GRID_SIDE));

    always_comb
    begin
        cmd_in.kind = (item.opcode == OP_EXAMINE) ? CMD_EXAMINE : CMD_WRITE;
        cmd_in.x    = item.cell_x;
        cmd_in.y    = item.cell_y;
        cmd_in.z    = item.cell_z;
        cmd_in.id   = item.block_id;
    end

    assign q_push = push && !full && in_grid;

    vfc_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .dout  (cmd),
        .empty (q_empty)
    );

    assign cmd_valid = !q_empty;

endmodule

// ===== sv/vfc_back.sv =====
module vfc_back #(
    parameter int GRID_SIDE = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [vfc_pkg::MASK_W-1:0] mask,
    input  vfc_pkg::cmd_t          cmd,
    input  logic                   cmd_valid,
    output logic                   cmd_pop,
    input  logic                   pop,
    output logic                   empty,
    output vfc_pkg::out_item_t     result
);

    import vfc_pkg::*;

    localparam int CW        = $clog2(GRID_SIDE);
    localparam int DEPTH     = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int AW        = $clog2(DEPTH);
    localparam int OUT_DEPTH = 4;
    localparam logic [CW-1:0] TOP   = CW'(GRID_SIDE - 1);
    localparam logic [AW-1:0] PLANE = AW'(GRID_SIDE * GRID_SIDE);
    localparam logic [AW-1:0] ROW   = AW'(GRID_SIDE);

    // read sequence: center cell, then the six sides, then the drain step
    localparam logic [2:0] STEP_CENTER = 3'd0;
    localparam logic [2:0] STEP_LEFT   = 3'd1;
    localparam logic [2:0] STEP_RIGHT  = 3'd2;
    localparam logic [2:0] STEP_UP     = 3'd3;
    localparam logic [2:0] STEP_DOWN   = 3'd4;
    localparam logic [2:0] STEP_FRONT  = 3'd5;
    localparam logic [2:0] STEP_BACK   = 3'd6;
    localparam logic [2:0] STEP_DRAIN  = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    function automatic logic [AW-1:0] cell_addr(logic [CW-1:0] x, logic [CW-1:0] y,
                                                 logic [CW-1:0] z);
        return AW'(x) * PLANE + AW'(y) * ROW + AW'(z);
    endfunction

    state_t                 state_reg, state_next;
    cmd_t                   cur_reg, cur_next;
    logic [2:0]             step_reg, step_next;
    logic                   pend_reg, pend_next;
    logic [2:0]             pend_step_reg, pend_step_next;
    logic                   center_clear_reg, center_clear_next;
    logic [SIDE_COUNT-1:0]  open_reg, open_next;

    logic [CW-1:0]          cx, cy, cz, nx, ny, nz;
    logic                   at_edge;
    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [ID_W-1:0]        ram_rdata;
    logic                   rd_clear;
    logic [2:0]             pend_side, step_side;

    logic [SIDE_W-1:0]      sel;
    logic [SIDE_COUNT-1:0]  remain;
    out_item_t              rec;
    logic                   out_push, out_full;

    assign cx = CW'(cur_reg.x);
    assign cy = CW'(cur_reg.y);
    assign cz = CW'(cur_reg.z);

    // neighbor coordinates for the current step, with grid edge detect
    always_comb
    begin
        nx      = cx;
        ny      = cy;
        nz      = cz;
        at_edge = 1'b0;
        unique case (step_reg)
            STEP_CENTER: ;
            STEP_LEFT:
            begin
                at_edge = (cx == '0);
                nx      = cx - 1'b1;
            end
            STEP_RIGHT:
            begin
                at_edge = (cx == TOP);
                nx      = cx + 1'b1;
            end
            STEP_UP:
            begin
                at_edge = (cy == TOP);
                ny      = cy + 1'b1;
            end
            STEP_DOWN:
            begin
                at_edge = (cy == '0);
                ny      = cy - 1'b1;
            end
            STEP_FRONT:
            begin
                at_edge = (cz == '0);
                nz      = cz - 1'b1;
            end
            STEP_BACK:
            begin
                at_edge = (cz == TOP);
                nz      = cz + 1'b1;
            end
            default: ;
        endcase
    end

    assign ram_waddr = cell_addr(CW'(cmd.x), CW'(cmd.y), CW'(cmd.z));
    assign ram_raddr = cell_addr(nx, ny, nz);
    assign rd_clear  = mask[ram_rdata];
    assign pend_side = pend_step_reg - 1'b1;
    assign step_side = step_reg - 1'b1;

    // lowest open side goes out first
    always_comb
    begin
        sel = SIDE_BACK;
        for (int k = SIDE_COUNT - 1; k >= 0; k--)
        begin
            if (open_reg[k])
            begin
                sel = SIDE_W'(k);
            end
        end
        remain = open_reg & ~(SIDE_COUNT'(1) << sel);
    end

    always_comb
    begin
        rec.face_x    = cur_reg.x;
        rec.face_y    = cur_reg.y;
        rec.face_z    = cur_reg.z;
        rec.face_side = sel;
        rec.last_face = (remain == '0);
    end

    always_comb
    begin
        state_next        = state_reg;
        cur_next          = cur_reg;
        step_next         = step_reg;
        pend_next         = 1'b0;
        pend_step_next    = step_reg;
        center_clear_next = center_clear_reg;
        open_next         = open_reg;
        cmd_pop           = 1'b0;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        out_push          = 1'b0;

        // collect the read issued last cycle
        if (pend_reg)
        begin
            if (pend_step_reg == STEP_CENTER)
            begin
                center_clear_next = rd_clear;
            end
            else
            begin
                open_next[pend_side] = rd_clear;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.kind == CMD_WRITE)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        cur_next   = cmd;
                        step_next  = STEP_CENTER;
                        open_next  = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (step_reg == STEP_DRAIN)
                begin
                    if (center_clear_next || (open_next == '0))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    if (at_edge)
                    begin
                        open_next[step_side] = 1'b1;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        pend_next = 1'b1;
                    end
                    step_next = step_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!out_full)
                begin
                    out_push  = 1'b1;
                    open_next = remain;
                    if (remain == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_CENTER;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg          <= cur_next;
        pend_step_reg    <= pend_step_next;
        center_clear_reg <= center_clear_next;
        open_reg         <= open_next;
    end

    vfc_ram #(
        .WIDTH (ID_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.id),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    vfc_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (rec),
        .full  (out_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

endmodule

// ===== sv/voxel_face_culling.sv =====
// path: a write lands in the grid once the back end pops it from the command queue;
//   an examine queues its first face record after its reads and the drain step
// throughput: one write per cycle when the back end is idle; an examine holds the
//   back end, set by the single read port of the voxel store (up to 7 reads in turn)
// reset: queues and sequencer empty and idle, transparent mask = 1 (only id 0 clear);
//   grid contents are undefined until written, no clearing pass
module voxel_face_culling #(
    parameter int GRID_SIDE = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // input queue side
    input  logic               push,
    input  vfc_pkg::in_item_t  item,
    output logic               full,
    // result queue side
    output logic               empty,
    input  logic               pop,
    output vfc_pkg::out_item_t result,
    // transparent mask register
    input  logic               cfg_write,
    input  logic [63:0]        cfg_data
);

    import vfc_pkg::*;

    logic [MASK_W-1:0] transparent_mask_reg;
    cmd_t              cmd;
    logic              cmd_valid;
    logic              cmd_pop;

    // transparency mask, bit i set means block id i lets light through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transparent_mask_reg <= MASK_W'(1);
        end
        else if (cfg_write)
        begin
            transparent_mask_reg <= cfg_data;
        end
    end

    // front end: takes each transaction, drops off-grid cells, classifies
    // write versus examine and queues the command
    vfc_front #(
        .GRID_SIDE (GRID_SIDE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    // back end: owns the voxel store, walks center and six neighbors for
    // an examine, then, unless the center is clear, pushes one face record per open side in side order
    vfc_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mask      (transparent_mask_reg),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule
